// ===== hw/rtl/mlfq_pkg.sv =====
package mlfq_pkg;

    // Sizing of the queue store
    localparam int LEVELS      = 4;
    localparam int QUEUE_DEPTH = 64;
    localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths fixed by the interface
    localparam int ID_W      = 8;
    localparam int WORK_W    = 10;
    localparam int ENTRY_W   = ID_W + WORK_W;
    localparam int STATUS_W  = 3;
    localparam int RUN_LVL_W = 2;
    localparam int NL_W      = 3;
    localparam int QUANT_W   = 10;
    localparam int QUANTS    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM3   = 3'd4;

    // Commands
    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_SLICE    = 3'd1,
        ST_FINISHED = 3'd2,
        ST_IDLE     = 3'd3,
        ST_REJECTED = 3'd4,
        ST_BLOCKED  = 3'd5
    } status_t;

    // One pointer-table operation per cycle
    typedef struct packed {
        logic             pop;
        logic             push;
        logic [LVL_W-1:0] lvl;
    } ptr_op_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [PTR_W-1:0] ptr);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH);
        return base + ADDR_W'(ptr);
    endfunction

endpackage

// ===== hw/rtl/mlfq_ram.sv =====
module mlfq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/mlfq_ptrs.sv =====
module mlfq_ptrs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mlfq_pkg::ptr_op_t              op,
    output logic [mlfq_pkg::LEVELS-1:0]    nonempty,
    output logic [mlfq_pkg::LEVELS-1:0]    full,
    output logic [mlfq_pkg::PTR_W-1:0]     head,
    output logic [mlfq_pkg::PTR_W-1:0]     tail
);
    import mlfq_pkg::*;

    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] tail_reg [LEVELS];
    logic [CNT_W-1:0] fill_reg [LEVELS];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Per-level status and pointers of the selected level
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            nonempty[i] = (fill_reg[i] != '0);
            full[i]     = (fill_reg[i] == CNT_W'(QUEUE_DEPTH));
        end
        head = head_reg[op.lvl];
        tail = tail_reg[op.lvl];
    end

    // Pointer and count update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (op.pop)
        begin
            head_reg[op.lvl] <= ptr_inc(head_reg[op.lvl]);
            fill_reg[op.lvl] <= fill_reg[op.lvl] - 1'b1;
        end
        else if (op.push)
        begin
            tail_reg[op.lvl] <= ptr_inc(tail_reg[op.lvl]);
            fill_reg[op.lvl] <= fill_reg[op.lvl] + 1'b1;
        end
    end

endmodule

// ===== hw/rtl/multilevel_feedback_queue_scheduler_top.sv =====
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   cmd, job_id, work_needed
// response  out        rsp_valid/rsp_stall   status, run_job, run_level, slice_used, work_left
// config    in         cfg_we                cfg_index, cfg_data
//
// One transaction at a time. An add, or a dispatch with nothing queued, loads the response
// register from the execute state once the output is free; a dispatch that pops a job goes
// on to a read state for the registered RAM read and writes the requeued job back as it responds.
// Reset clears the per-level pointers and counts; the queue RAM is not cleared.
// A stalled response holds the block before its next result; a new request may be taken
// while a finished response is still waiting.
module multilevel_feedback_queue_scheduler_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                cmd,
    input  logic [mlfq_pkg::ID_W-1:0]           job_id,
    input  logic [mlfq_pkg::WORK_W-1:0]         work_needed,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [mlfq_pkg::STATUS_W-1:0]       status,
    output logic [mlfq_pkg::ID_W-1:0]           run_job,
    output logic [mlfq_pkg::RUN_LVL_W-1:0]      run_level,
    output logic [mlfq_pkg::WORK_W-1:0]         slice_used,
    output logic [mlfq_pkg::WORK_W-1:0]         work_left,
    input  logic                                cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mlfq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [NL_W-1:0]    num_levels_reg;
    logic [QUANT_W-1:0] quantum_reg [QUANTS];

    // Request registers
    logic               cmd_reg;
    logic [ID_W-1:0]    id_reg;
    logic [WORK_W-1:0]  work_reg;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;

    // Response registers
    logic               rsp_valid_reg, rsp_valid_next;
    status_t            status_reg, status_next;
    logic [ID_W-1:0]    job_reg, job_next;
    logic [LVL_W-1:0]   rlvl_reg, rlvl_next;
    logic [WORK_W-1:0]  used_reg, used_next;
    logic [WORK_W-1:0]  left_reg, left_next;

    // Pointer table and RAM hookup
    ptr_op_t            op;
    logic [LEVELS-1:0]  nonempty, full;
    logic [PTR_W-1:0]   head, tail;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    // Dispatch arithmetic
    logic               out_free, load_rsp;
    logic               found;
    logic [LVL_W-1:0]   found_lvl;
    logic [WORK_W-1:0]  rem, q_eff, used, left;
    logic [NL_W-1:0]    nl_eff;
    logic [LVL_W:0]     lvl_up;
    logic [LEVELS:0]    full_ext;
    logic               demote_ok;

    mlfq_ptrs u_ptrs (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .nonempty (nonempty),
        .full     (full),
        .head     (head),
        .tail     (tail)
    );

    mlfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign run_job    = job_reg;
    assign run_level  = RUN_LVL_W'(rlvl_reg);
    assign slice_used = used_reg;
    assign work_left  = left_reg;

    // Highest-priority nonempty level
    always_comb
    begin
        found_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                found_lvl = LVL_W'(i);
            end
        end
        found = |nonempty;
    end

    // Slice and requeue decision for the popped entry
    always_comb
    begin
        rem      = ram_rdata[WORK_W-1:0];
        q_eff    = (quantum_reg[lvl_reg] == '0) ? WORK_W'(1) : quantum_reg[lvl_reg];
        if (num_levels_reg == '0)
        begin
            nl_eff = NL_W'(1);
        end
        else if (num_levels_reg > NL_W'(LEVELS))
        begin
            nl_eff = NL_W'(LEVELS);
        end
        else
        begin
            nl_eff = num_levels_reg;
        end
        used      = (rem < q_eff) ? rem : q_eff;
        left      = rem - used;
        lvl_up    = {1'b0, lvl_reg} + 1'b1;
        full_ext  = {1'b1, full};
        demote_ok = (NL_W'(lvl_up) < nl_eff) && !full_ext[lvl_up];
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        op          = '{pop: 1'b0, push: 1'b0, lvl: '0};
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = '0;
        ram_raddr   = '0;
        ram_wdata   = '0;
        load_rsp    = 1'b0;
        status_next = status_reg;
        job_next    = job_reg;
        rlvl_next   = rlvl_reg;
        used_next   = used_reg;
        left_next   = left_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    // Add to the tail of the top level
                    op.lvl = '0;
                    if (out_free)
                    begin
                        load_rsp   = 1'b1;
                        job_next   = id_reg;
                        rlvl_next  = '0;
                        used_next  = '0;
                        state_next = S_IDLE;
                        if (full[0])
                        begin
                            status_next = ST_REJECTED;
                            left_next   = '0;
                        end
                        else
                        begin
                            op.push     = 1'b1;
                            ram_we      = 1'b1;
                            ram_waddr   = store_addr('0, tail);
                            ram_wdata   = {id_reg, work_reg};
                            status_next = ST_ADDED;
                            left_next   = work_reg;
                        end
                    end
                end
                else if (found)
                begin
                    // Pop the head of the chosen level
                    op.lvl     = found_lvl;
                    op.pop     = 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = store_addr(found_lvl, head);
                    lvl_next   = found_lvl;
                    state_next = S_READ;
                end
                else if (out_free)
                begin
                    load_rsp    = 1'b1;
                    status_next = ST_IDLE;
                    job_next    = '0;
                    rlvl_next   = '0;
                    used_next   = '0;
                    left_next   = '0;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
            begin
                op.lvl = demote_ok ? LVL_W'(lvl_up) : lvl_reg;
                if (out_free)
                begin
                    load_rsp   = 1'b1;
                    job_next   = ram_rdata[ENTRY_W-1:WORK_W];
                    rlvl_next  = lvl_reg;
                    used_next  = used;
                    left_next  = left;
                    state_next = S_IDLE;
                    if (left == '0)
                    begin
                        status_next = ST_FINISHED;
                    end
                    else
                    begin
                        op.push   = 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = store_addr(op.lvl, tail);
                        ram_wdata = {ram_rdata[ENTRY_W-1:WORK_W], left};
                        if (demote_ok || (NL_W'(lvl_up) >= nl_eff))
                        begin
                            status_next = ST_SLICE;
                        end
                        else
                        begin
                            status_next = ST_BLOCKED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = load_rsp ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            num_levels_reg <= NL_W'(4);
            quantum_reg[0] <= QUANT_W'(1);
            quantum_reg[1] <= QUANT_W'(2);
            quantum_reg[2] <= QUANT_W'(4);
            quantum_reg[3] <= QUANT_W'(8);
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_NUM_LEVELS)
                begin
                    num_levels_reg <= cfg_data[NL_W-1:0];
                end
                else if (cfg_index inside {[CFG_QUANTUM0:CFG_QUANTUM3]})
                begin
                    quantum_reg[2'(cfg_index - CFG_QUANTUM0)] <= cfg_data[QUANT_W-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            cmd_reg  <= cmd;
            id_reg   <= job_id;
            work_reg <= work_needed;
        end
        lvl_reg <= lvl_next;
        if (load_rsp)
        begin
            status_reg <= status_next;
            job_reg    <= job_next;
            rlvl_reg   <= rlvl_next;
            used_reg   <= used_next;
            left_reg   <= left_next;
        end
    end

endmodule

// ===== hw/rtl/mlfq_checker.sv =====
module mlfq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_stall,
    input logic                            rsp_valid,
    input logic                            rsp_stall,
    input logic [mlfq_pkg::STATUS_W-1:0]   status,
    input logic [mlfq_pkg::ID_W-1:0]       run_job,
    input logic [mlfq_pkg::WORK_W-1:0]     slice_used,
    input logic [mlfq_pkg::WORK_W-1:0]     work_left
);
    import mlfq_pkg::*;

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(run_job)
            && $stable(slice_used) && $stable(work_left))
        else $error("stalled response changed");

    // One transaction at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // Only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status <= ST_BLOCKED)
        else $error("undefined status code");

    // Idle dispatch carries an all-zero payload
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_IDLE |-> run_job == '0 && slice_used == '0
            && work_left == '0)
        else $error("idle response with payload");

    // Finished means nothing left; a requeued job has work left
    a_left_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FINISHED || status == ST_SLICE || status == ST_BLOCKED)
            |-> ((status == ST_FINISHED) == (work_left == '0)))
        else $error("work left disagrees with status");

endmodule

bind multilevel_feedback_queue_scheduler_top mlfq_checker u_mlfq_checker (.*);
